// ===== rtl/amx_pkg.sv =====
// amx_pkg: shared types and field positions for the multiply execute unit
// no dependencies
`default_nettype none

package amx_pkg;

	localparam int unsigned RegIdxW   = 4;
	localparam int unsigned WordW     = 32;
	localparam int unsigned HalfW     = 16;
	localparam int unsigned RdLoLsb   = 12;
	localparam int unsigned RdHiLsb   = 16;
	localparam int unsigned SBit      = 20;
	localparam int unsigned ABit      = 21;
	localparam int unsigned UBit      = 22;

	typedef enum logic {
		OP_SHORT = 1'b0,
		OP_LONG  = 1'b1
	} amx_op_t;

	typedef struct packed {
		logic        operation;
		logic [31:0] instruction;
		logic [31:0] multiplicand;
		logic [31:0] multiplier;
		logic [31:0] addend_short;
		logic [31:0] addend_low;
		logic [31:0] addend_high;
	} amx_req_t;

	typedef struct packed {
		logic [3:0]  primary_index;
		logic [31:0] primary_value;
		logic        primary_write;
		logic [3:0]  secondary_index;
		logic [31:0] secondary_value;
		logic        secondary_write;
		logic        flags_write;
		logic        zero_flag;
		logic        negative_flag;
		logic        undefined_instruction;
	} amx_rsp_t;

	// decoded control that rides along the pipeline
	typedef struct packed {
		amx_op_t     op;
		logic        s_bit;
		logic        und;
		logic [3:0]  p_idx;
		logic [3:0]  s_idx;
	} amx_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/arm_multiply_execute.sv =====
// arm_multiply_execute: MUL, MLA, UMULL, SMULL, UMLAL, SMLAL execute unit
// depends on amx_pkg
//
//  channel   | signals               | transfer when
//  ----------+-----------------------+-------------------------------
//  request   | start, busy, request  | rising edge with start & !busy
//  result    | done, result          | rising edge ending a done cycle
//
// one instruction per cycle
// stages: operand decode, two 33x17 partial products, product sum,
// accumulate add, flag and write-enable output register
// busy is tied low; the receiver takes every result as presented
// reset clears only the valid bits
`default_nettype none

module arm_multiply_execute import amx_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire amx_req_t request,
	output logic          done,
	output amx_rsp_t      result
);

	logic        accept;
	amx_ctl_t    ctl_d;
	logic        sgn_d;
	logic        acc_d;

	logic        v_s1, v_s2, v_s3, v_s4, done_q;
	amx_ctl_t    ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [32:0] a_s1, b_s1;
	logic [63:0] addend_s1, addend_s2, addend_s3;
	logic signed [49:0] pp_lo_s2, pp_hi_s2;
	logic [63:0] prod_s3;
	logic [63:0] sum_s4;
	amx_rsp_t    rsp_q;

	logic [63:0] pp_lo_ext, pp_hi_ext;
	logic        zero_w, neg_w, fw_w, wr_w;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// decode
	always_comb begin
		ctl_d.op    = amx_op_t'(request.operation);
		ctl_d.s_bit = request.instruction[SBit];
		ctl_d.p_idx = (ctl_d.op == OP_LONG) ?
			request.instruction[RdLoLsb +: RegIdxW] :
			request.instruction[RdHiLsb +: RegIdxW];
		ctl_d.s_idx = (ctl_d.op == OP_LONG) ?
			request.instruction[RdHiLsb +: RegIdxW] : '0;
		ctl_d.und   = (ctl_d.op == OP_LONG) &&
			(request.instruction[RdLoLsb +: RegIdxW] ==
			 request.instruction[RdHiLsb +: RegIdxW]);
		sgn_d = (ctl_d.op == OP_LONG) & request.instruction[UBit];
		acc_d = request.instruction[ABit];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= accept;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			done_q <= v_s4;
		end
	end

	// stage 1: operands sign or zero extended, addend selected
	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl_d;
			a_s1   <= {sgn_d & request.multiplicand[WordW-1], request.multiplicand};
			b_s1   <= {sgn_d & request.multiplier[WordW-1], request.multiplier};
			if (!acc_d)
				addend_s1 <= '0;
			else if (ctl_d.op == OP_LONG)
				addend_s1 <= {request.addend_high, request.addend_low};
			else
				addend_s1 <= {32'd0, request.addend_short};
		end
	end

	// stage 2: partial products on the low and high halves of the multiplier
	always_ff @(posedge clk) begin
		if (v_s1) begin
			ctl_s2    <= ctl_s1;
			addend_s2 <= addend_s1;
			pp_lo_s2  <= $signed(a_s1) * $signed({1'b0, b_s1[HalfW-1:0]});
			pp_hi_s2  <= $signed(a_s1) * $signed(b_s1[32:HalfW]);
		end
	end

	assign pp_lo_ext = {{14{pp_lo_s2[49]}}, pp_lo_s2};
	assign pp_hi_ext = {pp_hi_s2[47:0], 16'd0};

	// stage 3: full product
	always_ff @(posedge clk) begin
		if (v_s2) begin
			ctl_s3    <= ctl_s2;
			addend_s3 <= addend_s2;
			prod_s3   <= pp_lo_ext + pp_hi_ext;
		end
	end

	// stage 4: accumulate
	always_ff @(posedge clk) begin
		if (v_s3) begin
			ctl_s4 <= ctl_s3;
			sum_s4 <= prod_s3 + addend_s3;
		end
	end

	// output stage: flags and write enables
	always_comb begin
		wr_w = ~ctl_s4.und;
		fw_w = ctl_s4.s_bit & ~ctl_s4.und;
		if (ctl_s4.op == OP_LONG) begin
			zero_w = (sum_s4 == 64'd0);
			neg_w  = sum_s4[63];
		end else begin
			zero_w = (sum_s4[31:0] == 32'd0);
			neg_w  = sum_s4[31];
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4) begin
			rsp_q.primary_index         <= ctl_s4.p_idx;
			rsp_q.primary_value         <= wr_w ? sum_s4[31:0] : '0;
			rsp_q.primary_write         <= wr_w;
			rsp_q.secondary_index       <= ctl_s4.s_idx;
			rsp_q.secondary_value       <= (wr_w && ctl_s4.op == OP_LONG) ?
				sum_s4[63:32] : '0;
			rsp_q.secondary_write       <= wr_w & (ctl_s4.op == OP_LONG);
			rsp_q.flags_write           <= fw_w;
			rsp_q.zero_flag             <= fw_w & zero_w;
			rsp_q.negative_flag         <= fw_w & neg_w;
			rsp_q.undefined_instruction <= ctl_s4.und;
		end
	end

	assign done   = done_q;
	assign result = rsp_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##5 done)
		else $error("result strobe missing five cycles after acceptance");

	a_und_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.undefined_instruction) |->
			(!result.primary_write && !result.secondary_write && !result.flags_write))
		else $error("undefined instruction writes a destination or flags");

	a_flags_masked: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.flags_write) |-> (!result.zero_flag && !result.negative_flag))
		else $error("flags set without flag write");

	a_secondary_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.secondary_write) |-> (result.secondary_value == 32'd0))
		else $error("high half nonzero without high write");

endmodule

`default_nettype wire

// ===== tb/sv/amx_writeback_pkg.sv =====
`timescale 1ns / 1ps
// amx_writeback_pkg: scoreboard for the multiply execute unit, predicts the
// register writeback and flags of each issued multiply; depends on amx_pkg

package amx_writeback_pkg;
	import amx_pkg::*;

	class writeback_board;
		amx_rsp_t pending_writebacks[$];
		int unsigned failures;

		function new();
			failures = 0;
		endfunction

		static function amx_rsp_t compute_writeback(amx_req_t rq);
			amx_rsp_t wb;
			logic [3:0] lo_idx;
			logic [3:0] hi_idx;
			logic s_f;
			logic a_f;
			logic u_f;
			logic [63:0] lhs;
			logic [63:0] rhs;
			logic [63:0] full;
			wb = '0;
			lo_idx = rq.instruction[RdLoLsb +: RegIdxW];
			hi_idx = rq.instruction[RdHiLsb +: RegIdxW];
			s_f = rq.instruction[SBit];
			a_f = rq.instruction[ABit];
			u_f = rq.instruction[UBit];
			if (rq.operation == OP_SHORT) begin
				full = {32'd0, rq.multiplicand} * {32'd0, rq.multiplier};
				if (a_f) begin
					full = full + {32'd0, rq.addend_short};
				end
				wb.primary_index = hi_idx;
				wb.primary_value = full[31:0];
				wb.primary_write = 1'b1;
				if (s_f) begin
					wb.flags_write = 1'b1;
					wb.zero_flag = (full[31:0] == 32'd0);
					wb.negative_flag = full[31];
				end
			end else begin
				wb.primary_index = lo_idx;
				wb.secondary_index = hi_idx;
				if (lo_idx == hi_idx) begin
					wb.undefined_instruction = 1'b1;
				end else begin
					// sign extension only matters in the upper half of the 64-bit product
					lhs = {{32{u_f & rq.multiplicand[31]}}, rq.multiplicand};
					rhs = {{32{u_f & rq.multiplier[31]}}, rq.multiplier};
					full = lhs * rhs;
					if (a_f) begin
						full = full + {rq.addend_high, rq.addend_low};
					end
					wb.primary_value = full[31:0];
					wb.secondary_value = full[63:32];
					wb.primary_write = 1'b1;
					wb.secondary_write = 1'b1;
					if (s_f) begin
						wb.flags_write = 1'b1;
						wb.zero_flag = (full == 64'd0);
						wb.negative_flag = full[63];
					end
				end
			end
			return wb;
		endfunction

		function void note_issue(amx_req_t rq);
			pending_writebacks.push_back(compute_writeback(rq));
		endfunction

		function int unsigned pending();
			return pending_writebacks.size();
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%08h, got 0x%08h", name, want, got);
				failures++;
			end
		endfunction

		function void check_writeback(amx_rsp_t got);
			amx_rsp_t want;
			if (pending_writebacks.size() == 0) begin
				$error("writeback transfer with no multiply pending");
				failures++;
			end else begin
				want = pending_writebacks.pop_front();
				compare_field("primary_index", 32'(want.primary_index),
					32'(got.primary_index));
				compare_field("primary_value", want.primary_value, got.primary_value);
				compare_field("primary_write", 32'(want.primary_write),
					32'(got.primary_write));
				compare_field("secondary_index", 32'(want.secondary_index),
					32'(got.secondary_index));
				compare_field("secondary_value", want.secondary_value, got.secondary_value);
				compare_field("secondary_write", 32'(want.secondary_write),
					32'(got.secondary_write));
				compare_field("flags_write", 32'(want.flags_write),
					32'(got.flags_write));
				compare_field("zero_flag", 32'(want.zero_flag), 32'(got.zero_flag));
				compare_field("negative_flag", 32'(want.negative_flag),
					32'(got.negative_flag));
				compare_field("undefined_instruction", 32'(want.undefined_instruction),
					32'(got.undefined_instruction));
			end
		endfunction
	endclass

endpackage

// ===== tb/sv/arm_multiply_execute_test.sv =====
`timescale 1ns / 1ps
// arm_multiply_execute_test: directed and random multiply instructions issued
// in bursts, every writeback checked; depends on amx_pkg, amx_writeback_pkg

module arm_multiply_execute_test;
	import amx_pkg::*;
	import amx_writeback_pkg::*;

	localparam int unsigned LATENCY = 5;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned RANDOM_ITEMS = 1300;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	amx_req_t request;
	amx_rsp_t result;
	writeback_board board = new();
	int unsigned cycles = 0;

	arm_multiply_execute uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done) begin
			board.check_writeback(result);
		end
	end

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return 32'h8000_0000;
			3: return 32'h7fff_ffff;
			4: return 32'h0000_0001;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] encode(logic [31:0] noise, logic [3:0] hi, logic [3:0] lo,
			int unsigned s_f, int unsigned a_f, int unsigned u_f);
		logic [31:0] word;
		word = noise;
		word[RdHiLsb +: RegIdxW] = hi;
		word[RdLoLsb +: RegIdxW] = lo;
		word[SBit] = s_f[0];
		word[ABit] = a_f[0];
		word[UBit] = u_f[0];
		return word;
	endfunction

	function automatic amx_req_t make_req(amx_op_t op, logic [31:0] word, logic [31:0] rm_val,
			logic [31:0] rs_val, logic [31:0] rn_val, logic [31:0] lo_val, logic [31:0] hi_val);
		amx_req_t rq;
		rq.operation = op;
		rq.instruction = word;
		rq.multiplicand = rm_val;
		rq.multiplier = rs_val;
		rq.addend_short = rn_val;
		rq.addend_low = lo_val;
		rq.addend_high = hi_val;
		return rq;
	endfunction

	function automatic amx_req_t random_req();
		logic [31:0] word;
		word = $urandom;
		// push the long form into the undefined case more often than chance
		if ($urandom_range(0, 7) == 0) begin
			word[RdLoLsb +: RegIdxW] = word[RdHiLsb +: RegIdxW];
		end
		return make_req(amx_op_t'($urandom_range(0, 1)), word, pick_operand(), pick_operand(),
			pick_operand(), pick_operand(), pick_operand());
	endfunction

	task automatic issue(amx_req_t rq);
		start <= 1'b1;
		request <= rq;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		board.note_issue(rq);
	endtask

	task automatic idle_for(int unsigned n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (board.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin : stimulus
		int unsigned sent;
		int unsigned burst;
		bit held;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		held = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short form: zero, max, wrap to zero, negative, no flags
		issue(make_req(OP_SHORT, encode(32'h0, 4'd1, 4'd2, 1, 0, 0), 0, 0, '1, '1, '1));
		issue(make_req(OP_SHORT, encode($urandom, 4'd15, 4'd0, 1, 0, 1), '1, '1, 0, '1, '1));
		issue(make_req(OP_SHORT, encode($urandom, 4'd3, 4'd4, 1, 1, 0), 1, '1, 1, 0, 0));
		issue(make_req(OP_SHORT, encode(32'h0, 4'd6, 4'd6, 1, 1, 0),
			32'h8000_0000, 1, 0, '1, '1));
		issue(make_req(OP_SHORT, encode($urandom, 4'd7, 4'd8, 0, 1, 0),
			32'h1234_5678, 32'h9abc_def0, '1, 0, 0));
		// long form: unsigned and signed extremes, accumulate wrap to zero
		issue(make_req(OP_LONG, encode($urandom, 4'd5, 4'd4, 1, 0, 0), '1, '1, 0, '1, '1));
		issue(make_req(OP_LONG, encode($urandom, 4'd1, 4'd0, 1, 0, 1),
			32'h8000_0000, 32'h8000_0000, 0, 0, 0));
		issue(make_req(OP_LONG, encode($urandom, 4'd2, 4'd3, 1, 0, 1), '1, 1, 0, 0, 0));
		issue(make_req(OP_LONG, encode($urandom, 4'd14, 4'd13, 1, 0, 1),
			32'h7fff_ffff, 32'h8000_0000, 0, 0, 0));
		issue(make_req(OP_LONG, encode($urandom, 4'd10, 4'd11, 1, 1, 0),
			1, '1, 0, 32'h0000_0001, '1));
		issue(make_req(OP_LONG, encode($urandom, 4'd12, 4'd9, 1, 1, 1), '1, '1, 0, '1, '1));
		issue(make_req(OP_LONG, encode($urandom, 4'd8, 4'd15, 0, 1, 1),
			$urandom, $urandom, $urandom, $urandom, $urandom));
		issue(make_req(OP_LONG, encode($urandom, 4'd0, 4'd15, 0, 0, 0), '1, '1, 0, 0, 0));
		// long form with equal destinations
		issue(make_req(OP_LONG, encode($urandom, 4'd0, 4'd0, 1, 0, 0), '1, '1, 0, '1, '1));
		issue(make_req(OP_LONG, encode($urandom, 4'd15, 4'd15, 1, 1, 1), '1, 1, 0, '1, '1));
		issue(make_req(OP_LONG, encode($urandom, 4'd7, 4'd7, 0, 1, 0), 5, 7, 0, 1, 1));
		issue(make_req(OP_LONG, encode($urandom, 4'd9, 4'd9, 1, 0, 1), 0, 0, 0, 0, 0));
		// whole instruction word at its extremes
		issue(make_req(OP_SHORT, '1, '1, '1, '1, '1, '1));
		issue(make_req(OP_LONG, '1, '1, '1, '1, '1, '1));
		issue(make_req(OP_LONG, '0, 0, 0, 0, 0, 0));
		issue(make_req(OP_SHORT, '0, 0, 0, 0, 0, 0));
		drain();

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 32);
			repeat (burst) begin
				issue(random_req());
				sent++;
			end
			if (!held && sent >= RANDOM_ITEMS / 2) begin
				held = 1'b1;
				drain();
			end else if ($urandom_range(0, 3) != 0) begin
				idle_for($urandom_range(1, 2 * LATENCY));
			end
		end
		drain();
		repeat (2 * LATENCY) @(posedge clk);

		if (board.failures == 0 && board.pending() == 0) begin
			$display("arm_multiply_execute regression: pass");
		end else begin
			$display("arm_multiply_execute regression: fail");
		end
		$finish;
	end

	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("arm_multiply_execute regression: fail");
		$finish;
	end

endmodule

// ===== arm_multiply_execute.f =====
rtl/amx_pkg.sv
rtl/arm_multiply_execute.sv
tb/sv/amx_writeback_pkg.sv
tb/sv/arm_multiply_execute_test.sv
